// ----- rtl/core/rtpu_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Radix integer text parser: shared definitions
// Widths, character codes, status codes and the queue entry that carries a
// classified text beat from the front end to the back end.
// ---------------------------------------------------------------------------
package rtpu_pkg;

  // Result width and the accumulator that holds one multiply-add step.
  localparam int VALUE_WIDTH = 64;
  localparam int ACC_WIDTH   = VALUE_WIDTH + 6;

  // Largest magnitude accepted: the most positive value of the signed result.
  localparam logic [ACC_WIDTH-1:0] MAX_MAGNITUDE =
    {{(ACC_WIDTH-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};

  // Radix register and the radices it can resolve to.
  localparam int RADIX_WIDTH = 6;
  localparam logic [RADIX_WIDTH-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_WIDTH-1:0] RADIX_UNARY = 6'd1;
  localparam logic [RADIX_WIDTH-1:0] RADIX_BIN   = 6'd2;
  localparam logic [RADIX_WIDTH-1:0] RADIX_OCT   = 6'd8;
  localparam logic [RADIX_WIDTH-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_WIDTH-1:0] RADIX_HEX   = 6'd16;
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;

  // Configuration register indexes.
  localparam int CFG_INDEX_WIDTH = 1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIX  = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STRICT = 1'b1;

  // Depth of the queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
  localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_D  = 8'h64;
  localparam logic [7:0] CH_LO_O  = 8'h6F;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_INVALID,
    STATUS_BAD_RADIX,
    STATUS_OVERFLOW
  } status_t;

  // One classified text beat.
  typedef struct packed {
    logic                   present;
    logic                   last;
    logic                   nul;
    logic                   blank;
    logic                   plus;
    logic                   minus;
    logic                   zero_char;
    logic                   underscore;
    logic                   pfx_x;
    logic                   pfx_b;
    logic                   pfx_o;
    logic                   pfx_d;
    logic                   octal;
    logic                   digit_ok;
    logic [RADIX_WIDTH-1:0] digit;
  } item_t;

endpackage
`default_nettype wire

// ----- rtl/core/rtpu_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Radix integer text parser: front end classifier
// Sorts each incoming byte into the character classes the parser needs and
// works out its raw digit value, ready to be queued for the back end.
// ---------------------------------------------------------------------------
module rtpu_front (
  input  logic [7:0]      text_byte,
  input  logic            byte_present,
  input  logic            last,
  output rtpu_pkg::item_t item
);
  import rtpu_pkg::*;

  logic [7:0] folded;
  logic       is_num;
  logic       is_lower;
  logic       is_upper;

  // Folding to lower case makes the prefix letters case-blind.
  assign folded   = text_byte | CASE_BIT;
  assign is_num   = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign is_lower = (text_byte >= CH_LO_A) && (text_byte <= CH_LO_Z);
  assign is_upper = (text_byte >= CH_UP_A) && (text_byte <= CH_UP_Z);

  // Character classes.
  always_comb begin
    item.present    = byte_present;
    item.last       = last;
    item.nul        = (text_byte == CH_NUL);
    item.blank      = (text_byte == CH_SPACE) ||
                      ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
    item.plus       = (text_byte == CH_PLUS);
    item.minus      = (text_byte == CH_MINUS);
    item.zero_char  = (text_byte == CH_ZERO);
    item.underscore = (text_byte == CH_USCORE);
    item.pfx_x      = (folded == CH_LO_X);
    item.pfx_b      = (folded == CH_LO_B);
    item.pfx_o      = (folded == CH_LO_O);
    item.pfx_d      = (folded == CH_LO_D);
    item.octal      = (text_byte >= CH_ZERO) && (text_byte <= CH_SEVEN);
    item.digit_ok   = is_num || is_lower || is_upper;
  end

  // Raw digit value, 0 to 35; the radix check happens in the back end.
  always_comb begin
    priority if (is_num) begin
      item.digit = RADIX_WIDTH'(text_byte - CH_ZERO);
    end else if (is_lower) begin
      item.digit = RADIX_WIDTH'(text_byte - CH_LO_A + 8'd10);
    end else if (is_upper) begin
      item.digit = RADIX_WIDTH'(text_byte - CH_UP_A + 8'd10);
    end else begin
      item.digit = '0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rtpu_queue.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Radix integer text parser: item queue
// A short first-word-fall-through queue of classified beats that lets the
// front end keep taking text while the back end waits on its output.
// ---------------------------------------------------------------------------
module rtpu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rtpu_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output rtpu_pkg::item_t head_item
);
  import rtpu_pkg::*;

  item_t                store [QUEUE_DEPTH];
  logic [PTR_WIDTH-1:0] wr_ptr;
  logic [PTR_WIDTH-1:0] rd_ptr;
  logic [CNT_WIDTH-1:0] count;

  assign full       = (count == CNT_WIDTH'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = store[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rtpu_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Radix integer text parser: back end
// Holds the configuration registers and parse state, applies one queued beat
// per cycle (with multiply-add and overflow check) unless a last beat waits
// on a stalled output, and keeps the finished result in an output register.
// ---------------------------------------------------------------------------
module rtpu_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [rtpu_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [rtpu_pkg::RADIX_WIDTH-1:0]       cfg_data,
  input  logic                                   q_valid,
  input  rtpu_pkg::item_t                        q_item,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rtpu_pkg::VALUE_WIDTH-1:0] value,
  output logic [1:0]                             status
);
  import rtpu_pkg::*;

  typedef enum logic [2:0] {
    PH_WS,
    PH_SIGNED,
    PH_ZERO,
    PH_SCAN,
    PH_TRAIL,
    PH_DONE
  } phase_t;

  // Configuration.
  logic [RADIX_WIDTH-1:0] radix_setting;
  logic                   strict_mode;

  // Parse state.
  phase_t                 phase;
  logic                   negative;
  logic [RADIX_WIDTH-1:0] active_radix;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic                   seen_digit;
  logic                   underscore_pending;
  logic                   zero_pending;
  status_t                sticky_error;

  // Result register.
  logic [VALUE_WIDTH-1:0] res_mag;
  logic                   res_neg;
  status_t                res_status;

  // Next-state values.
  phase_t                 phase_next;
  logic                   negative_next;
  logic [RADIX_WIDTH-1:0] active_radix_next;
  logic [VALUE_WIDTH-1:0] magnitude_next;
  logic                   seen_digit_next;
  logic                   underscore_pending_next;
  logic                   zero_pending_next;
  status_t                sticky_error_next;
  logic [VALUE_WIDTH-1:0] res_mag_next;
  logic                   res_neg_next;
  status_t                res_status_next;

  logic                   do_head;
  logic                   do_zero;
  logic                   do_scan;
  logic                   prefix_skip;
  logic                   digit_valid;
  logic                   go_acc;
  logic                   go_stop;
  logic                   allow_trail;
  logic [ACC_WIDTH-1:0]   acc;

  // A last beat needs the output register to be free or draining.
  assign q_pop = q_valid && (!q_item.last || !out_valid || !out_stall);

  // The stored magnitude is zero whenever the status is not OK.
  assign value  = res_neg ? (VALUE_WIDTH'(0) - res_mag) : res_mag;
  assign status = res_status;

  // Per-beat parse step: head handling, prefix resolution and digit scan.
  always_comb begin
    phase_next              = phase;
    negative_next           = negative;
    active_radix_next       = active_radix;
    magnitude_next          = magnitude;
    seen_digit_next         = seen_digit;
    underscore_pending_next = underscore_pending;
    zero_pending_next       = zero_pending;
    sticky_error_next       = sticky_error;
    do_head                 = 1'b0;
    do_zero                 = 1'b0;
    do_scan                 = 1'b0;
    prefix_skip             = 1'b0;
    go_acc                  = 1'b0;
    go_stop                 = 1'b0;
    allow_trail             = 1'b0;

    // The radix is sampled while still in leading whitespace.
    if (phase == PH_WS) begin
      active_radix_next = radix_setting;
      if ((radix_setting == RADIX_UNARY) || (radix_setting > RADIX_MAX)) begin
        sticky_error_next = STATUS_BAD_RADIX;
        phase_next        = PH_DONE;
      end
    end

    if (q_item.present) begin
      if (phase_next == PH_DONE) begin
        if (q_item.nul && strict_mode) begin
          sticky_error_next = STATUS_INVALID;
        end
      end else if (q_item.nul) begin
        // A zero byte ends the string.
        if (strict_mode) begin
          sticky_error_next = STATUS_INVALID;
        end
        phase_next = PH_DONE;
      end else begin
        unique case (phase_next)
          PH_WS: begin
            priority if (q_item.blank) begin
              phase_next = PH_WS;
            end else if (q_item.plus) begin
              phase_next = PH_SIGNED;
            end else if (q_item.minus) begin
              negative_next = 1'b1;
              phase_next    = PH_SIGNED;
            end else begin
              do_head = 1'b1;
            end
          end
          PH_SIGNED: do_head = 1'b1;
          PH_ZERO:   do_zero = 1'b1;
          PH_SCAN:   do_scan = 1'b1;
          PH_TRAIL: begin
            if (!q_item.blank) begin
              if (strict_mode) begin
                sticky_error_next = STATUS_INVALID;
              end
              phase_next = PH_DONE;
            end
          end
          PH_DONE: phase_next = PH_DONE;
          default: phase_next = PH_DONE;
        endcase
      end
    end

    // First significant byte: a leading zero may start a prefix.
    if (do_head) begin
      if (q_item.zero_char) begin
        phase_next        = PH_ZERO;
        zero_pending_next = 1'b1;
      end else begin
        if (active_radix_next == RADIX_AUTO) begin
          active_radix_next = RADIX_DEC;
        end
        phase_next = PH_SCAN;
        do_scan    = 1'b1;
      end
    end

    // Byte after a leading zero: pick the radix and skip a matching prefix.
    if (do_zero) begin
      if (active_radix_next == RADIX_AUTO) begin
        priority if (q_item.pfx_x) begin
          active_radix_next = RADIX_HEX;
        end else if (q_item.pfx_b) begin
          active_radix_next = RADIX_BIN;
        end else if (q_item.pfx_o || q_item.octal) begin
          active_radix_next = RADIX_OCT;
        end else begin
          active_radix_next = RADIX_DEC;
        end
      end
      prefix_skip = ((active_radix_next == RADIX_HEX) && q_item.pfx_x) ||
                    ((active_radix_next == RADIX_BIN) && q_item.pfx_b) ||
                    ((active_radix_next == RADIX_OCT) && q_item.pfx_o) ||
                    ((active_radix_next == RADIX_DEC) && q_item.pfx_d);
      zero_pending_next = 1'b0;
      phase_next        = PH_SCAN;
      // Otherwise the held zero counts as a digit; the magnitude stays zero.
      if (!prefix_skip) begin
        seen_digit_next = 1'b1;
        do_scan         = 1'b1;
      end
    end

    // Digit scan with underscore rule.
    digit_valid = q_item.digit_ok && (q_item.digit < active_radix_next);
    if (do_scan) begin
      if (underscore_pending_next) begin
        underscore_pending_next = 1'b0;
        if (digit_valid) begin
          go_acc = 1'b1;
        end else begin
          go_stop = 1'b1;
        end
      end else if (digit_valid) begin
        go_acc = 1'b1;
      end else if (q_item.underscore && seen_digit_next) begin
        underscore_pending_next = 1'b1;
      end else begin
        go_stop     = 1'b1;
        allow_trail = 1'b1;
      end
    end

    // Multiply-add; the bound check on the wide sum replaces a division.
    acc = ACC_WIDTH'(magnitude_next) * ACC_WIDTH'(active_radix_next) +
          ACC_WIDTH'(q_item.digit);
    if (go_acc) begin
      if (acc > MAX_MAGNITUDE) begin
        sticky_error_next = STATUS_OVERFLOW;
        phase_next        = PH_DONE;
      end else begin
        magnitude_next  = acc[VALUE_WIDTH-1:0];
        seen_digit_next = 1'b1;
      end
    end

    // Unusable byte: trailing blanks are allowed after digits in strict mode.
    if (go_stop) begin
      if (strict_mode) begin
        if (allow_trail && q_item.blank && seen_digit_next) begin
          phase_next = PH_TRAIL;
        end else begin
          sticky_error_next = STATUS_INVALID;
          phase_next        = PH_DONE;
        end
      end else begin
        phase_next = PH_DONE;
      end
    end
  end

  // Result of a string that ends with this beat.
  always_comb begin
    res_mag_next    = '0;
    res_status_next = STATUS_OK;
    if (sticky_error_next != STATUS_OK) begin
      res_status_next = sticky_error_next;
    end else if (!strict_mode) begin
      res_mag_next = seen_digit_next ? magnitude_next : '0;
    end else begin
      unique case (phase_next)
        PH_ZERO: res_mag_next = '0;
        PH_SCAN: begin
          if (underscore_pending_next || !seen_digit_next) begin
            res_status_next = STATUS_INVALID;
          end else begin
            res_mag_next = magnitude_next;
          end
        end
        PH_TRAIL, PH_DONE: begin
          if (seen_digit_next) begin
            res_mag_next = magnitude_next;
          end else begin
            res_status_next = STATUS_INVALID;
          end
        end
        default: res_status_next = STATUS_INVALID;
      endcase
    end
    res_neg_next = negative_next && (res_status_next == STATUS_OK);
  end

  // Configuration, parse state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_setting      <= RADIX_AUTO;
      strict_mode        <= 1'b1;
      phase              <= PH_WS;
      negative           <= 1'b0;
      active_radix       <= RADIX_AUTO;
      magnitude          <= '0;
      seen_digit         <= 1'b0;
      underscore_pending <= 1'b0;
      zero_pending       <= 1'b0;
      sticky_error       <= STATUS_OK;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RADIX:  radix_setting <= cfg_data;
          REG_STRICT: strict_mode   <= cfg_data[0];
          default:    radix_setting <= radix_setting;
        endcase
      end

      if (q_pop && q_item.last) begin
        // String finished: start the next one from a clean state.
        phase              <= PH_WS;
        negative           <= 1'b0;
        active_radix       <= RADIX_AUTO;
        magnitude          <= '0;
        seen_digit         <= 1'b0;
        underscore_pending <= 1'b0;
        zero_pending       <= 1'b0;
        sticky_error       <= STATUS_OK;
      end else if (q_pop) begin
        phase              <= phase_next;
        negative           <= negative_next;
        active_radix       <= active_radix_next;
        magnitude          <= magnitude_next;
        seen_digit         <= seen_digit_next;
        underscore_pending <= underscore_pending_next;
        zero_pending       <= zero_pending_next;
        sticky_error       <= sticky_error_next;
      end

      if (q_pop && q_item.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end

    if (q_pop && q_item.last) begin
      res_mag    <= res_mag_next;
      res_neg    <= res_neg_next;
      res_status <= res_status_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/radix_integer_text_parser_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Radix integer text parser unit
// Turns a byte stream of text into a signed integer with status, one
// result per string.
// ---------------------------------------------------------------------------
// A string arrives as a run of input beats, one byte each, and the beat
// marked last yields one result beat carrying the value and a status code
// (ok, invalid value, invalid radix, overflow). The unit takes one beat per
// cycle while its queue has room; that rate is set by the back end, which
// applies the multiply-add and overflow check of a byte as it takes the
// beat. A result is registered and shown in the cycle after its last beat
// is taken. A four-entry queue between the classifying front end and the
// back end absorbs output stalls, and the input stalls only when it is full.
// Configuration writes take effect at once and should be made between
// strings.
module radix_integer_text_parser_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [rtpu_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [rtpu_pkg::RADIX_WIDTH-1:0]       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [7:0]                             text_byte,
  input  logic                                   byte_present,
  input  logic                                   last,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rtpu_pkg::VALUE_WIDTH-1:0] value,
  output logic [1:0]                             status
);
  import rtpu_pkg::*;

  item_t front_item;
  item_t head_item;
  logic  queue_full;
  logic  head_valid;
  logic  head_pop;
  logic  push;

  // Input beats are taken whenever the queue has room.
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Classify the incoming byte.
  rtpu_front u_front (
    .text_byte    (text_byte),
    .byte_present (byte_present),
    .last         (last),
    .item         (front_item)
  );

  // Queue between front and back end.
  rtpu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (front_item),
    .full       (queue_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Parse state, configuration and result register.
  rtpu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (head_valid),
    .q_item    (head_item),
    .q_pop     (head_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
  );

endmodule
`default_nettype wire
